FILE: rtl/bpq_pkg.sv
package bpq_pkg;

    localparam int TILE_W     = 16;
    localparam int TILE_COUNT = 1 << TILE_W;
    localparam int KEY_W      = 8;
    localparam int NUM_KEYS   = 1 << KEY_W;
    localparam int GRP_W      = 4;
    localparam int BIT_W      = KEY_W - GRP_W;
    localparam int NUM_GRPS   = 1 << GRP_W;
    localparam int GRP_SIZE   = 1 << BIT_W;
    localparam int COUNT_W    = 17;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int LINK_W     = TILE_W + 1;

    // queued flag memory holds the epoch of the push; zero means not queued
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PUSHED    = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_POPPED    = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_CLEARED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_PUSH,
        S_POP_KEY,
        S_POP_HEAD,
        S_POP_WR,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   head_raddr;
        logic               head_we;
        logic [KEY_W-1:0]   head_waddr;
        logic [TILE_W-1:0]  head_wdata;
        logic [TILE_W-1:0]  link_raddr;
        logic               link_we;
        logic [TILE_W-1:0]  link_waddr;
        logic [LINK_W-1:0]  link_wdata;   // {valid, next tile}
        logic [TILE_W-1:0]  flag_raddr;
        logic               flag_we;
        logic [TILE_W-1:0]  flag_waddr;
        logic [EPOCH_W-1:0] flag_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [TILE_W-1:0]  head_rdata;
        logic [LINK_W-1:0]  link_rdata;
        logic [EPOCH_W-1:0] flag_rdata;
    } mem_rsp_t;

    typedef struct packed {
        status_t             status;
        logic [TILE_W-1:0]   popped_tile;
        logic [KEY_W-1:0]    popped_key;
        logic [COUNT_W-1:0]  queue_count;
        logic                queue_empty;
    } result_t;

endpackage

FILE: rtl/bpq_store.sv
module bpq_store (
    input  logic              aclk,
    input  bpq_pkg::mem_req_t req,
    output bpq_pkg::mem_rsp_t rsp
);

    logic [bpq_pkg::TILE_W-1:0]  head_mem [bpq_pkg::NUM_KEYS];
    logic [bpq_pkg::LINK_W-1:0]  link_mem [bpq_pkg::TILE_COUNT];
    logic [bpq_pkg::EPOCH_W-1:0] flag_mem [bpq_pkg::TILE_COUNT];

    always_ff @(posedge aclk) begin
        if (req.head_we) begin
            head_mem[req.head_waddr] <= req.head_wdata;
        end
        if (req.link_we) begin
            link_mem[req.link_waddr] <= req.link_wdata;
        end
        if (req.flag_we) begin
            flag_mem[req.flag_waddr] <= req.flag_wdata;
        end
        rsp.head_rdata <= head_mem[req.head_raddr];
        rsp.link_rdata <= link_mem[req.link_raddr];
        rsp.flag_rdata <= flag_mem[req.flag_raddr];
    end

endmodule

FILE: rtl/bpq_prio.sv
module bpq_prio (
    input  logic [bpq_pkg::NUM_KEYS-1:0] head_valid,
    input  logic [bpq_pkg::GRP_W-1:0]    grp_sel,
    output logic                         grp_found,
    output logic [bpq_pkg::GRP_W-1:0]    grp_idx,
    output logic [bpq_pkg::BIT_W-1:0]    bit_idx
);

    logic [bpq_pkg::GRP_SIZE-1:0] sel_slice;

    // highest non-empty group of buckets
    always_comb begin
        grp_found = 1'b0;
        grp_idx   = '0;
        for (int i = 0; i < bpq_pkg::NUM_GRPS; i++) begin
            if (|head_valid[i*bpq_pkg::GRP_SIZE +: bpq_pkg::GRP_SIZE]) begin
                grp_found = 1'b1;
                grp_idx   = bpq_pkg::GRP_W'(i);
            end
        end
    end

    // highest non-empty bucket inside the chosen group
    assign sel_slice = head_valid[grp_sel*bpq_pkg::GRP_SIZE +: bpq_pkg::GRP_SIZE];

    always_comb begin
        bit_idx = '0;
        for (int j = 0; j < bpq_pkg::GRP_SIZE; j++) begin
            if (sel_slice[j]) begin
                bit_idx = bpq_pkg::BIT_W'(j);
            end
        end
    end

endmodule

FILE: rtl/bpq_ctrl.sv
module bpq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpq_pkg::MODE_W-1:0]    in_mode,
    input  logic [bpq_pkg::TILE_W-1:0]    in_tile,
    input  logic [bpq_pkg::KEY_W-1:0]     in_key,
    input  logic                          out_free,
    output logic                          res_load,
    output bpq_pkg::result_t              res,
    output bpq_pkg::mem_req_t             req,
    input  bpq_pkg::mem_rsp_t             rsp
);

    bpq_pkg::state_t state_reg, state_next;

    logic [bpq_pkg::TILE_W-1:0]   tile_reg, tile_next;
    logic [bpq_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [bpq_pkg::GRP_W-1:0]    grp_reg, grp_next;
    logic                         found_reg, found_next;
    logic [bpq_pkg::TILE_W-1:0]   h_reg, h_next;
    logic [bpq_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [bpq_pkg::EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [bpq_pkg::TILE_W-1:0]   sweep_reg, sweep_next;
    logic [bpq_pkg::NUM_KEYS-1:0] head_valid_reg, head_valid_next;

    logic                         grp_found;
    logic [bpq_pkg::GRP_W-1:0]    grp_idx;
    logic [bpq_pkg::BIT_W-1:0]    bit_idx;

    bpq_prio u_prio (
        .head_valid (head_valid_reg),
        .grp_sel    (grp_reg),
        .grp_found  (grp_found),
        .grp_idx    (grp_idx),
        .bit_idx    (bit_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bpq_pkg::S_SWEEP;
            sweep_reg      <= '0;
            epoch_reg      <= bpq_pkg::EPOCH_FIRST;
            count_reg      <= '0;
            head_valid_reg <= '0;
            found_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            epoch_reg      <= epoch_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        tile_reg <= tile_next;
        key_reg  <= key_next;
        grp_reg  <= grp_next;
        h_reg    <= h_next;
    end

    always_comb begin
        state_next      = state_reg;
        tile_next       = tile_reg;
        key_next        = key_reg;
        grp_next        = grp_reg;
        found_next      = found_reg;
        h_next          = h_reg;
        count_next      = count_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        head_valid_next = head_valid_reg;
        s_tready        = 1'b0;
        res_load        = 1'b0;
        res.status      = bpq_pkg::STAT_EMPTY;
        res.popped_tile = '0;
        res.popped_key  = '0;

        req.head_we    = 1'b0;
        req.head_waddr = key_reg;
        req.head_wdata = tile_reg;
        req.link_we    = 1'b0;
        req.link_waddr = tile_reg;
        req.link_wdata = {head_valid_reg[key_reg], rsp.head_rdata};
        req.flag_we    = 1'b0;
        req.flag_waddr = tile_reg;
        req.flag_wdata = epoch_reg;

        case (state_reg)
            bpq_pkg::S_SWEEP: begin
                req.flag_we    = 1'b1;
                req.flag_waddr = sweep_reg;
                req.flag_wdata = bpq_pkg::EPOCH_NONE;
                sweep_next     = sweep_reg + 1'b1;
                if (&sweep_reg) begin
                    state_next = bpq_pkg::S_IDLE;
                end
            end
            bpq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (in_mode)
                        bpq_pkg::MODE_PUSH: begin
                            tile_next  = in_tile;
                            key_next   = in_key;
                            state_next = bpq_pkg::S_PUSH;
                        end
                        bpq_pkg::MODE_POP: begin
                            grp_next   = grp_idx;
                            found_next = grp_found;
                            state_next = bpq_pkg::S_POP_KEY;
                        end
                        default: begin
                            state_next = bpq_pkg::S_CLEAR;
                        end
                    endcase
                end
            end
            bpq_pkg::S_PUSH: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = bpq_pkg::S_IDLE;
                    if (rsp.flag_rdata == epoch_reg) begin
                        res.status = bpq_pkg::STAT_DUPLICATE;
                    end else begin
                        res.status               = bpq_pkg::STAT_PUSHED;
                        req.link_we              = 1'b1;
                        req.head_we              = 1'b1;
                        req.flag_we              = 1'b1;
                        head_valid_next[key_reg] = 1'b1;
                        count_next               = count_reg + 1'b1;
                    end
                end
            end
            bpq_pkg::S_POP_KEY: begin
                if (!found_reg) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res.status = bpq_pkg::STAT_EMPTY;
                        state_next = bpq_pkg::S_IDLE;
                    end
                end else begin
                    key_next   = {grp_reg, bit_idx};
                    state_next = bpq_pkg::S_POP_HEAD;
                end
            end
            bpq_pkg::S_POP_HEAD: begin
                h_next     = rsp.head_rdata;
                state_next = bpq_pkg::S_POP_WR;
            end
            bpq_pkg::S_POP_WR: begin
                if (out_free) begin
                    // unlink the bucket's newest tile
                    req.head_we              = 1'b1;
                    req.head_wdata           = rsp.link_rdata[bpq_pkg::TILE_W-1:0];
                    head_valid_next[key_reg] = rsp.link_rdata[bpq_pkg::TILE_W];
                    req.flag_we              = 1'b1;
                    req.flag_waddr           = h_reg;
                    req.flag_wdata           = bpq_pkg::EPOCH_NONE;
                    count_next               = count_reg - 1'b1;
                    res_load                 = 1'b1;
                    res.status               = bpq_pkg::STAT_POPPED;
                    res.popped_tile          = h_reg;
                    res.popped_key           = key_reg;
                    state_next               = bpq_pkg::S_IDLE;
                end
            end
            bpq_pkg::S_CLEAR: begin
                if (out_free) begin
                    head_valid_next = '0;
                    count_next      = '0;
                    res_load        = 1'b1;
                    res.status      = bpq_pkg::STAT_CLEARED;
                    if (epoch_reg == bpq_pkg::EPOCH_MAX) begin
                        // epoch space used up: wipe stale flags before reuse
                        epoch_next = bpq_pkg::EPOCH_FIRST;
                        sweep_next = '0;
                        state_next = bpq_pkg::S_SWEEP;
                    end else begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = bpq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = bpq_pkg::S_IDLE;
            end
        endcase

        res.queue_count = count_next;
        res.queue_empty = (count_next == '0);

        // read addresses follow the next register values so data lines up
        req.head_raddr = key_next;
        req.flag_raddr = tile_next;
        req.link_raddr = h_next;
    end

endmodule

FILE: rtl/bucket_priority_queue_unit.sv
// A push runs through S_PUSH; a pop through S_POP_KEY, S_POP_HEAD and S_POP_WR; a pop
// on empty ends in S_POP_KEY and a clear in S_CLEAR, each waiting for a free output register.
// Items are taken only in S_IDLE, one item in flight, since each does a read-then-write
// walk through the head, link and queued-flag memories. Reset (aresetn low, synchronous)
// empties the queue, then a clearing pass wipes the queued-flag memory while s_tready
// stays low. Every 15th clear item runs the same pass after its result.
module bucket_priority_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // tile_index[15:0], key[23:16]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // popped_tile[15:0], popped_key[23:16],
                                   // queue_count[40:24], queue_empty[41], zero[47:42]
    output logic [2:0]  m_tuser    // status[2:0]
);

    bpq_pkg::mem_req_t req;
    bpq_pkg::mem_rsp_t rsp;
    bpq_pkg::result_t  res;
    bpq_pkg::result_t  out_reg;
    logic              out_valid_reg;
    logic              res_load;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;

    bpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser),
        .in_tile  (s_tdata[15:0]),
        .in_key   (s_tdata[23:16]),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res),
        .req      (req),
        .rsp      (rsp)
    );

    bpq_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'b0, out_reg.queue_empty, out_reg.queue_count,
                       out_reg.popped_key, out_reg.popped_tile};

endmodule

FILE: rtl/bpq_checker.sv
module bpq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // one item in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[41] == (m_tdata[40:24] == 17'd0)))
    else $error("empty flag disagrees with count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != bpq_pkg::STAT_POPPED) |-> (m_tdata[23:0] == 24'd0))
    else $error("popped fields set without a pop");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bpq_pkg::STAT_CLEARED) |-> (m_tdata[40:24] == 17'd0))
    else $error("clear left a nonzero count");

endmodule

bind bucket_priority_queue_unit bpq_checker u_bpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

// Mirrors the queue in software and keeps the results still owed by the block.
class tile_queue_board;
    logic [bpq_pkg::TILE_W-1:0]  head_tile [bpq_pkg::NUM_KEYS];
    bit                          head_ok   [bpq_pkg::NUM_KEYS];
    logic [bpq_pkg::LINK_W-1:0]  next_link [bpq_pkg::TILE_COUNT];   // {valid, next tile}
    bit                          queued    [bpq_pkg::TILE_COUNT];
    logic [bpq_pkg::KEY_W-1:0]   top_key;
    bit                          top_ok;
    logic [bpq_pkg::COUNT_W-1:0] tile_count;
    bpq_pkg::result_t            owed_results [$];
    int                          errors;

    function new();
        errors = 0;
        foreach (next_link[i]) next_link[i] = '0;
        empty_queue();
    endfunction

    function void empty_queue();
        foreach (head_ok[i]) begin
            head_ok[i]   = 1'b0;
            head_tile[i] = '0;
        end
        foreach (queued[i]) queued[i] = 1'b0;
        top_key    = '0;
        top_ok     = 1'b0;
        tile_count = '0;
    endfunction

    function int outstanding();
        return owed_results.size();
    endfunction

    // Accepted item: update the mirror and queue up the result it should produce.
    function void note_op(logic [bpq_pkg::MODE_W-1:0] mode, logic [bpq_pkg::TILE_W-1:0] tile,
                          logic [bpq_pkg::KEY_W-1:0] key);
        bpq_pkg::result_t           r;
        logic [bpq_pkg::TILE_W-1:0] h;
        r = '0;
        if (mode[1]) begin
            // both clear codes decode on the high bit
            empty_queue();
            r.status = bpq_pkg::STAT_CLEARED;
        end else if (mode == bpq_pkg::MODE_PUSH) begin
            if (queued[tile]) begin
                r.status = bpq_pkg::STAT_DUPLICATE;
            end else begin
                next_link[tile] = {head_ok[key], head_tile[key]};
                head_tile[key]  = tile;
                head_ok[key]    = 1'b1;
                if (!top_ok || key > top_key) begin
                    top_key = key;
                    top_ok  = 1'b1;
                end
                queued[tile] = 1'b1;
                tile_count   = tile_count + 1'b1;
                r.status     = bpq_pkg::STAT_PUSHED;
            end
        end else begin
            r.status = bpq_pkg::STAT_EMPTY;
            // walk the hint down past empty buckets; hint drops out below key zero
            while (top_ok && !head_ok[top_key]) begin
                if (top_key == '0) top_ok = 1'b0;
                else top_key = top_key - 1'b1;
            end
            if (top_ok) begin
                h = head_tile[top_key];
                {head_ok[top_key], head_tile[top_key]} = next_link[h];
                next_link[h] = '0;
                queued[h]    = 1'b0;
                if (tile_count != '0) tile_count = tile_count - 1'b1;
                r.status      = bpq_pkg::STAT_POPPED;
                r.popped_tile = h;
                r.popped_key  = top_key;
            end
        end
        r.queue_count = tile_count;
        r.queue_empty = (tile_count == '0);
        owed_results.push_back(r);
    endfunction

    function void check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%t: %s mismatch, expected %0h actual %0h", $time, fname, want_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(logic [2:0] status_bits, logic [47:0] data);
        bpq_pkg::result_t want;
        if (owed_results.size() == 0) begin
            $display("%t: unexpected result, expected none actual status %0h data %h",
                     $time, status_bits, data);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_bits));
        check_field("popped_tile", 32'(want.popped_tile), 32'(data[15:0]));
        check_field("popped_key", 32'(want.popped_key), 32'(data[23:16]));
        check_field("queue_count", 32'(want.queue_count), 32'(data[40:24]));
        check_field("queue_empty", 32'(want.queue_empty), 32'(data[41]));
        check_field("tdata pad", 32'd0, 32'(data[47:42]));
    endfunction
endclass

module tb_top;

    localparam logic [bpq_pkg::MODE_W-1:0] MODE_CLEAR     = 2'd2;
    localparam logic [bpq_pkg::MODE_W-1:0] MODE_CLEAR_ALT = 2'd3;   // high bit set, acts as clear
    localparam int LONG_HOLD = 400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    bit quiet        = 1'b0;
    bit hold_pending = 1'b0;

    tile_queue_board board = new();

    always #4 aclk = ~aclk;

    bucket_priority_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Offer one item and hold it until the block takes it. Called at a rising edge.
    task automatic send_op(input logic [bpq_pkg::MODE_W-1:0] mode,
                           input logic [bpq_pkg::TILE_W-1:0] tile,
                           input logic [bpq_pkg::KEY_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {key, tile};
        do @(posedge aclk); while (!s_tready);
        board.note_op(mode, tile, key);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Random ops; tiles come mostly from a small pool so duplicates and re-pushes occur.
    task automatic run_phase(input int n, input int push_pct, input int pop_pct);
        logic [bpq_pkg::MODE_W-1:0] mode;
        logic [bpq_pkg::TILE_W-1:0] tile;
        logic [bpq_pkg::KEY_W-1:0]  key;
        logic [bpq_pkg::TILE_W-1:0] pool_base;
        logic [bpq_pkg::KEY_W-1:0]  key_base;
        int                         pick;
        pool_base = bpq_pkg::TILE_W'($urandom);
        key_base  = bpq_pkg::KEY_W'($urandom);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) mode = bpq_pkg::MODE_PUSH;
            else if (pick < push_pct + pop_pct) mode = bpq_pkg::MODE_POP;
            else mode = $urandom_range(0, 1) ? MODE_CLEAR : MODE_CLEAR_ALT;
            if ($urandom_range(0, 3) != 0) begin
                tile = pool_base + bpq_pkg::TILE_W'($urandom_range(0, 23));
            end else begin
                tile = bpq_pkg::TILE_W'($urandom);
            end
            if ($urandom_range(0, 1) != 0) key = key_base + bpq_pkg::KEY_W'($urandom_range(0, 3));
            else key = bpq_pkg::KEY_W'($urandom_range(0, 255));
            send_op(mode, tile, key);
            maybe_gap();
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    // result side: check every accepted item, stall in random bursts or on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, extremes, duplicate, LIFO in one bucket, hint walk-down
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'hFFFF, 8'hFF);
        send_op(bpq_pkg::MODE_PUSH, 16'hFFFF, 8'h0A);
        send_op(bpq_pkg::MODE_PUSH, 16'h1234, 8'hFF);
        send_op(bpq_pkg::MODE_PUSH, 16'hABCD, 8'h80);
        send_op(bpq_pkg::MODE_POP,  16'hFFFF, 8'hFF);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'h5555, 8'hAA);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'hAAAA, 8'h55);
        send_op(MODE_CLEAR_ALT, 16'hFFFF, 8'hFF);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'hAAAA, 8'h55);
        send_op(bpq_pkg::MODE_PUSH, 16'h0007, 8'h01);
        send_op(MODE_CLEAR, 16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'h0007, 8'h01);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);
        send_op(bpq_pkg::MODE_PUSH, 16'h0007, 8'h01);
        send_op(bpq_pkg::MODE_POP,  16'h0000, 8'h00);

        run_phase(100, 85, 14);
        hold_pending = 1'b1;       // receiver backs off while items keep coming
        run_phase(100, 60, 38);
        run_phase(100, 20, 78);
        run_phase(120, 85, 14);
        wait_drained();
        run_phase(120, 60, 38);
        run_phase(100, 20, 78);
        run_phase(120, 60, 38);
        quiet = 1'b1;
        run_phase(120, 55, 43);

        wait_drained();
        repeat (16) @(posedge aclk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
